@@ hw/rtl/ccfr_pkg.sv @@
`timescale 1ns / 1ps
package ccfr_pkg;

    localparam int MAX_PAYLOAD     = 1024;
    localparam int STATE_BYTES     = 256;
    localparam int SPECT_BIN_COUNT = 128;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_OPCODE  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_LEN_HI  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CRC_LO  = 3'd5;
    localparam logic [2:0] PH_CRC_HI  = 3'd6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_LEN  = 3'd2;
    localparam logic [2:0] ST_BAD_CRC  = 3'd3;
    localparam logic [2:0] ST_BAD_VER  = 3'd4;
    localparam logic [2:0] ST_BAD_OP   = 3'd5;

    localparam logic [2:0] REG_MAGIC   = 3'd0;
    localparam logic [2:0] REG_FULL    = 3'd1;
    localparam logic [2:0] REG_PARTIAL = 3'd2;
    localparam logic [2:0] REG_TOUCH   = 3'd3;
    localparam logic [2:0] REG_HEART   = 3'd4;
    localparam logic [2:0] REG_SPECT   = 3'd5;
    localparam logic [2:0] REG_VERSION = 3'd6;

    typedef struct packed {
        logic [7:0] magic;
        logic [7:0] full_code;
        logic [7:0] partial_code;
        logic [7:0] touch_code;
        logic [7:0] heart_code;
        logic [7:0] spect_code;
        logic [7:0] version;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  opcode;
        logic [10:0] length;
        logic [15:0] noise;
    } res_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/ccfr_regs.sv @@
`timescale 1ns / 1ps
module ccfr_regs (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output ccfr_pkg::cfg_t cfg
);
    import ccfr_pkg::*;

    cfg_t cfg_reg;
    logic [2:0] idx;
    logic wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd0};
        end
        else if (wr)
        begin
            case (idx)
                REG_MAGIC:   cfg_reg.magic        <= pwdata[7:0];
                REG_FULL:    cfg_reg.full_code    <= pwdata[7:0];
                REG_PARTIAL: cfg_reg.partial_code <= pwdata[7:0];
                REG_TOUCH:   cfg_reg.touch_code   <= pwdata[7:0];
                REG_HEART:   cfg_reg.heart_code   <= pwdata[7:0];
                REG_SPECT:   cfg_reg.spect_code   <= pwdata[7:0];
                REG_VERSION: cfg_reg.version      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MAGIC:   prdata = {24'd0, cfg_reg.magic};
            REG_FULL:    prdata = {24'd0, cfg_reg.full_code};
            REG_PARTIAL: prdata = {24'd0, cfg_reg.partial_code};
            REG_TOUCH:   prdata = {24'd0, cfg_reg.touch_code};
            REG_HEART:   prdata = {24'd0, cfg_reg.heart_code};
            REG_SPECT:   prdata = {24'd0, cfg_reg.spect_code};
            REG_VERSION: prdata = {24'd0, cfg_reg.version};
            default:     prdata = 32'd0;
        endcase
    end
endmodule

@@ hw/rtl/ccfr_parser.sv @@
`timescale 1ns / 1ps
module ccfr_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  ccfr_pkg::cfg_t cfg,
    input  logic           in_go,
    input  logic [7:0]     b,
    output logic [1:0]     n_res,
    output ccfr_pkg::res_t res0,
    output ccfr_pkg::res_t res1
);
    import ccfr_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  op_reg, op_next;
    logic [15:0] len_reg, len_next;
    logic [10:0] cnt_reg, cnt_next;
    logic [7:0]  tlo_reg, tlo_next;
    logic [15:0] noise_reg, noise_next;
    logic [2:0]  cph_reg, cph_next;
    logic [15:0] coff_reg, coff_next;
    logic [15:0] crem_reg, crem_next;
    logic        cerr_reg, cerr_next;
    logic        verr_reg, verr_next;

    logic [15:0] crc_b, full_len, crem_full;
    logic [7:0]  h1;
    logic [16:0] sum_a, sum_b;
    logic [2:0]  judge;
    logic [10:0] sat_len;

    assign crc_b     = crc_byte(crc_reg, b);
    assign full_len  = {b, len_reg[7:0]};
    assign h1        = len_reg[7:0];
    assign crem_full = {b, crem_reg[7:0]};
    assign sum_a     = {6'd0, cnt_reg} + 17'd1 + {1'b0, crem_full};
    assign sum_b     = {1'b0, coff_reg} + {1'b0, crem_full};
    assign sat_len   = (len_reg > 16'd2047) ? 11'd2047 : len_reg[10:0];

    always_comb
    begin
        if (op_reg == cfg.full_code)
            judge = (len_reg != 16'(STATE_BYTES)) ? ST_BAD_LEN :
                    (verr_reg ? ST_BAD_VER : ST_OK);
        else if (op_reg == cfg.partial_code)
            judge = (cerr_reg || cph_reg != 3'd0) ? ST_BAD_LEN : ST_OK;
        else if (op_reg == cfg.touch_code)
            judge = (len_reg != 16'd5) ? ST_BAD_LEN : ST_OK;
        else if (op_reg == cfg.heart_code)
            judge = (len_reg != 16'd0) ? ST_BAD_LEN : ST_OK;
        else if (op_reg == cfg.spect_code)
            judge = (len_reg != 16'(2 * SPECT_BIN_COUNT)) ? ST_BAD_LEN : ST_OK;
        else
            judge = ST_BAD_OP;
    end

    always_comb
    begin
        phase_next = phase_reg; crc_next = crc_reg; op_next = op_reg;
        len_next = len_reg; cnt_next = cnt_reg; tlo_next = tlo_reg;
        noise_next = noise_reg; cph_next = cph_reg; coff_next = coff_reg;
        crem_next = crem_reg; cerr_next = cerr_reg; verr_next = verr_reg;
        n_res = 2'd0;
        res0 = '0;
        res1 = '0;
        case (phase_reg)
            PH_OPCODE:
            begin
                op_next = b; crc_next = crc_b; phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next = {8'd0, b}; crc_next = crc_b; phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_next = full_len;
                crc_next = crc_b;
                if (full_len > 16'(MAX_PAYLOAD))
                begin
                    n_res = 2'd1;
                    res0 = '{ST_BAD_LEN, op_reg,
                             (full_len > 16'd2047) ? 11'd2047 : full_len[10:0], 16'd0};
                    if (op_reg == cfg.magic)
                    begin
                        noise_next = 16'd0;
                        op_next = h1;
                        len_next = {8'd0, b};
                        crc_next = crc_byte(crc_byte(CRC_INIT, h1), b);
                        phase_next = PH_LEN_HI;
                    end
                    else if (h1 == cfg.magic)
                    begin
                        n_res = 2'd2;
                        res1 = '{ST_NO_MAGIC, 8'd0, 11'd0, 16'd1};
                        noise_next = 16'd0;
                        op_next = b;
                        crc_next = crc_byte(CRC_INIT, b);
                        phase_next = PH_LEN_LO;
                    end
                    else if (b == cfg.magic)
                    begin
                        n_res = 2'd2;
                        res1 = '{ST_NO_MAGIC, 8'd0, 11'd0, 16'd2};
                        noise_next = 16'd0;
                        crc_next = CRC_INIT;
                        phase_next = PH_OPCODE;
                    end
                    else
                    begin
                        noise_next = 16'd3;
                        phase_next = PH_HUNT;
                    end
                end
                else
                begin
                    cnt_next = 11'd0; cph_next = 3'd0; coff_next = 16'd0;
                    crem_next = 16'd0; cerr_next = 1'b0; verr_next = 1'b0;
                    phase_next = (full_len == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                crc_next = crc_b;
                if (cnt_reg == 11'd0 && b != cfg.version)
                    verr_next = 1'b1;
                if (!cerr_reg)
                begin
                    case (cph_reg)
                        3'd0: begin coff_next = {8'd0, b}; cph_next = 3'd1; end
                        3'd1: begin coff_next = {b, coff_reg[7:0]}; cph_next = 3'd2; end
                        3'd2: begin crem_next = {8'd0, b}; cph_next = 3'd3; end
                        3'd3:
                        begin
                            crem_next = crem_full;
                            if (sum_a > {1'b0, len_reg} || sum_b > 17'(STATE_BYTES))
                                cerr_next = 1'b1;
                            cph_next = (crem_full == 16'd0) ? 3'd0 : 3'd4;
                        end
                        default:
                        begin
                            if (crem_reg <= 16'd1)
                            begin
                                crem_next = 16'd0;
                                cph_next = 3'd0;
                            end
                            else
                                crem_next = crem_reg - 16'd1;
                        end
                    endcase
                end
                cnt_next = cnt_reg + 11'd1;
                if ({5'd0, cnt_next} >= len_reg)
                    phase_next = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                tlo_next = b; phase_next = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                n_res = 2'd1;
                res0 = '{({b, tlo_reg} != crc_reg) ? ST_BAD_CRC : judge,
                         op_reg, sat_len, 16'd0};
                phase_next = PH_HUNT;
                noise_next = 16'd0;
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (b == cfg.magic)
                begin
                    if (noise_reg != 16'd0)
                    begin
                        n_res = 2'd1;
                        res0 = '{ST_NO_MAGIC, 8'd0, 11'd0, noise_reg};
                    end
                    noise_next = 16'd0;
                    crc_next = CRC_INIT;
                    phase_next = PH_OPCODE;
                end
                else if (noise_reg != 16'hFFFF)
                    noise_next = noise_reg + 16'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT; crc_reg <= CRC_INIT; op_reg <= '0; len_reg <= '0;
            cnt_reg <= '0; tlo_reg <= '0; noise_reg <= '0; cph_reg <= '0;
            coff_reg <= '0; crem_reg <= '0; cerr_reg <= 1'b0; verr_reg <= 1'b0;
        end
        else if (in_go)
        begin
            phase_reg <= phase_next; crc_reg <= crc_next; op_reg <= op_next;
            len_reg <= len_next; cnt_reg <= cnt_next; tlo_reg <= tlo_next;
            noise_reg <= noise_next; cph_reg <= cph_next; coff_reg <= coff_next;
            crem_reg <= crem_next; cerr_reg <= cerr_next; verr_reg <= verr_next;
        end
    end
endmodule

@@ hw/rtl/crc_checked_frame_receiver.sv @@
`timescale 1ns / 1ps
// Byte-stream deframer: hunts for the magic byte, parses an opcode and a
// little-endian length, runs CRC16-CCITT over header and payload and reports
// one status request per frame, plus a no-magic request for skipped noise.
// Each link byte is handled in a single registered pass (bytewise CRC and
// header/chunk checks), so a byte can be accepted every cycle unless the
// output stalls. A byte that causes two results (bad length, then a no-magic
// report) holds the second in a one-entry slot; input stalls until it drains.
module crc_checked_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  frame_opcode,
    output logic [10:0] frame_length,
    output logic [15:0] noise_count,
    output logic        last
);
    import ccfr_pkg::*;

    cfg_t cfg;
    res_t res0, res1, out_reg, spare_reg;
    logic [1:0] n_res;
    logic out_v_reg, out_last_reg, spare_v_reg, in_go, out_free;

    ccfr_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    // The output register frees when empty or taken this cycle.
    assign out_free = !out_v_reg || !out_stall;
    assign in_stall = spare_v_reg || !out_free;
    assign in_go    = in_valid && !in_stall;

    ccfr_parser u_parser (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_go(in_go), .b(rx_byte),
        .n_res(n_res), .res0(res0), .res1(res1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg   <= 1'b0;
            spare_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (spare_v_reg)
            begin
                out_v_reg   <= 1'b1;
                spare_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg   <= in_go && (n_res != 2'd0);
                spare_v_reg <= in_go && (n_res == 2'd2);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (spare_v_reg)
            begin
                out_reg      <= spare_reg;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_reg      <= res0;
                out_last_reg <= (n_res != 2'd2);
                spare_reg    <= res1;
            end
        end
    end

    assign out_valid    = out_v_reg;
    assign status       = out_reg.status;
    assign frame_opcode = out_reg.opcode;
    assign frame_length = out_reg.length;
    assign noise_count  = out_reg.noise;
    assign last         = out_last_reg;
endmodule
